// ----- rtl/dats_pkg.sv -----
// Shared types and constants of the authorization-data type scanner.
`timescale 1ns / 1ps

package dats_pkg;

  localparam logic [7:0] TagSeq  = 8'h30;
  localparam logic [7:0] TagCtx0 = 8'hA0;
  localparam logic [7:0] TagInt  = 8'h02;
  localparam logic [7:0] TagCtx1 = 8'hA1;
  localparam logic [7:0] TagOct  = 8'h04;

  localparam int LongFormBit   = 7;
  localparam int MinElemBytes  = 6;
  localparam int TotalWidth    = 16;
  localparam int OffsetWidth   = 16;
  localparam int TypeWidth     = 31;
  localparam int AccWidth      = 32;
  localparam int EndWidth      = 33;
  localparam int CmpWidth      = 34;

  localparam logic [TypeWidth-1:0] TargetReset = 31'd128;

  typedef enum logic [19:0] {
    PhOuterTag  = 20'h00001,
    PhOuterLen  = 20'h00002,
    PhOuterMore = 20'h00004,
    PhElemTag   = 20'h00008,
    PhSeqLen    = 20'h00010,
    PhSeqMore   = 20'h00020,
    PhA0Tag     = 20'h00040,
    PhA0Len     = 20'h00080,
    PhA0More    = 20'h00100,
    PhIntTag    = 20'h00200,
    PhIntLen    = 20'h00400,
    PhIntVal    = 20'h00800,
    PhA1Tag     = 20'h01000,
    PhA1Len     = 20'h02000,
    PhA1More    = 20'h04000,
    PhOctTag    = 20'h08000,
    PhOctLen    = 20'h10000,
    PhOctMore   = 20'h20000,
    PhSkip      = 20'h40000,
    PhDone      = 20'h80000
  } phase_e;

  typedef enum logic [2:0] {
    StFound    = 3'd0,
    StBadOuter = 3'd1,
    StBadElem  = 3'd2,
    StDataEnd  = 3'd3,
    StBackSkip = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  first_byte;
    logic [TotalWidth-1:0] buffer_length;
  } item_t;

  typedef struct packed {
    logic                   found;
    logic [2:0]             status;
    logic [OffsetWidth-1:0] payload_offset;
    logic [TypeWidth-1:0]   payload_length;
  } result_t;

endpackage

// ----- rtl/dats_in_stage.sv -----
// Input register that holds one request ahead of the parser.
`timescale 1ns / 1ps

module dats_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dats_pkg::item_t item_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output dats_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  dats_pkg::item_t item_q;
  logic            load;

  assign in_ready_o   = !valid_q || take_i;
  assign load         = in_valid_i && in_ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/dats_core.sv -----
// Parser state and combinational next-state logic of the scanner.
`timescale 1ns / 1ps

module dats_core #(
  parameter int PositionWidth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dats_pkg::TypeWidth-1:0]    cfg_data_i,
  input  logic                              step_i,
  input  dats_pkg::item_t                   item_i,
  output logic                              emit_o,
  output dats_pkg::result_t                 res_o
);

  localparam int PW = PositionWidth;
  localparam int CW = dats_pkg::CmpWidth;
  localparam int EW = dats_pkg::EndWidth;
  localparam int AW = dats_pkg::AccWidth;
  localparam int TW = dats_pkg::TotalWidth;

  logic [dats_pkg::TypeWidth-1:0] target_q;
  logic [PW-1:0]                  pos_q, pos_d;
  dats_pkg::phase_e               phase_q, phase_d;
  logic [AW-1:0]                  lacc_q, lacc_d;
  logic [6:0]                     lleft_q, lleft_d;
  logic [AW-1:0]                  tacc_q, tacc_d;
  logic [7:0]                     tleft_q, tleft_d;
  logic [EW-1:0]                  eend_q, eend_d;
  logic [TW-1:0]                  tot_q, tot_d;
  logic                           given_q, given_d;

  logic                           live;
  logic                           ld_req;
  logic                           at_end;
  logic                           fin;
  dats_pkg::status_e              fin_st;
  logic [dats_pkg::OffsetWidth-1:0] fin_off;
  logic [dats_pkg::TypeWidth-1:0] fin_len;
  logic [7:0]                     b;
  logic [CW-1:0]                  pos_x;
  logic [CW-1:0]                  tot_x;
  logic [CW-1:0]                  end_x;

  function automatic logic [CW-1:0] ext_pos(input logic [PW-1:0] p);
    ext_pos = {{(CW-PW){1'b0}}, p};
  endfunction

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    lacc_d  = lacc_q;
    lleft_d = lleft_q;
    tacc_d  = tacc_q;
    tleft_d = tleft_q;
    eend_d  = eend_q;
    tot_d   = tot_q;
    given_d = given_q;
    live    = 1'b0;
    ld_req  = 1'b0;
    at_end  = 1'b0;
    fin     = 1'b0;
    fin_st  = dats_pkg::StFound;
    fin_off = '0;
    fin_len = '0;
    b       = item_i.data_byte;
    pos_x   = '0;
    tot_x   = '0;
    end_x   = '0;

    if (step_i) begin
      live = 1'b1;
      if (item_i.first_byte) begin
        pos_d   = '0;
        phase_d = dats_pkg::PhOuterTag;
        lacc_d  = '0;
        lleft_d = '0;
        tacc_d  = '0;
        tleft_d = '0;
        eend_d  = '0;
        given_d = 1'b0;
        tot_d   = item_i.buffer_length;
      end else if (given_q) begin
        live = 1'b0;
      end
    end

    tot_x = {{(CW-TW){1'b0}}, tot_d};

    if (live) begin
      if (ext_pos(pos_d) >= tot_x) begin
        fin     = 1'b1;
        fin_st  = dats_pkg::StDataEnd;
        phase_d = dats_pkg::PhDone;
      end else begin
        pos_d = pos_d + PW'(1);
        pos_x = ext_pos(pos_d);

        // advance on one byte
        unique case (phase_d)
          dats_pkg::PhOuterTag: begin
            if (b == dats_pkg::TagSeq) begin
              phase_d = dats_pkg::PhOuterLen;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadOuter; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhElemTag: begin
            if (b == dats_pkg::TagSeq) begin
              phase_d = dats_pkg::PhSeqLen;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhA0Tag: begin
            if (b == dats_pkg::TagCtx0) begin
              phase_d = dats_pkg::PhA0Len;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhIntTag: begin
            if (b == dats_pkg::TagInt) begin
              phase_d = dats_pkg::PhIntLen;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhA1Tag: begin
            if (b == dats_pkg::TagCtx1) begin
              phase_d = dats_pkg::PhA1Len;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhOctTag: begin
            if (b == dats_pkg::TagOct) begin
              phase_d = dats_pkg::PhOctLen;
            end else begin
              fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
            end
          end
          dats_pkg::PhOuterLen, dats_pkg::PhSeqLen, dats_pkg::PhA0Len,
          dats_pkg::PhA1Len, dats_pkg::PhOctLen: begin
            if (!b[dats_pkg::LongFormBit]) begin
              lacc_d = {{(AW-8){1'b0}}, b};
              ld_req = 1'b1;
            end else begin
              lacc_d  = '0;
              lleft_d = b[6:0];
              if (b[6:0] == 7'd0) begin
                ld_req = 1'b1;
              end else begin
                unique case (phase_d)
                  dats_pkg::PhOuterLen: phase_d = dats_pkg::PhOuterMore;
                  dats_pkg::PhSeqLen:   phase_d = dats_pkg::PhSeqMore;
                  dats_pkg::PhA0Len:    phase_d = dats_pkg::PhA0More;
                  dats_pkg::PhA1Len:    phase_d = dats_pkg::PhA1More;
                  default:              phase_d = dats_pkg::PhOctMore;
                endcase
              end
            end
          end
          dats_pkg::PhOuterMore, dats_pkg::PhSeqMore, dats_pkg::PhA0More,
          dats_pkg::PhA1More, dats_pkg::PhOctMore: begin
            lacc_d  = {lacc_d[AW-9:0], b};
            lleft_d = lleft_d - 7'd1;
            if (lleft_d == 7'd0) begin
              ld_req = 1'b1;
            end
          end
          dats_pkg::PhIntLen: begin
            tleft_d = b;
            tacc_d  = '0;
            phase_d = (b != 8'd0) ? dats_pkg::PhIntVal : dats_pkg::PhA1Tag;
          end
          dats_pkg::PhIntVal: begin
            tacc_d  = {tacc_d[AW-9:0], b};
            tleft_d = tleft_d - 8'd1;
            if (tleft_d == 8'd0) begin
              phase_d = dats_pkg::PhA1Tag;
            end
          end
          dats_pkg::PhSkip: begin
            if (pos_x == {1'b0, eend_d}) begin
              phase_d = dats_pkg::PhElemTag;
            end
          end
          default: begin
          end
        endcase

        at_end = pos_x >= tot_x;

        if (at_end && (phase_d == dats_pkg::PhOuterMore || phase_d == dats_pkg::PhSeqMore ||
                       phase_d == dats_pkg::PhA0More || phase_d == dats_pkg::PhA1More ||
                       phase_d == dats_pkg::PhOctMore)) begin
          ld_req = 1'b1;
        end

        // close a decoded length
        if (ld_req) begin
          unique case (phase_d)
            dats_pkg::PhOuterLen, dats_pkg::PhOuterMore: begin
              phase_d = dats_pkg::PhElemTag;
            end
            dats_pkg::PhSeqLen, dats_pkg::PhSeqMore: begin
              if (lacc_d[AW-1]) begin
                fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
              end else begin
                eend_d  = {{(EW-PW){1'b0}}, pos_d} + {1'b0, lacc_d};
                phase_d = dats_pkg::PhA0Tag;
              end
            end
            dats_pkg::PhA0Len, dats_pkg::PhA0More: begin
              phase_d = dats_pkg::PhIntTag;
            end
            dats_pkg::PhA1Len, dats_pkg::PhA1More: begin
              phase_d = dats_pkg::PhOctTag;
            end
            default: begin
              end_x = {1'b0, eend_d};
              if (lacc_d[AW-1]) begin
                fin = 1'b1; fin_st = dats_pkg::StBadElem; phase_d = dats_pkg::PhDone;
              end else if (tacc_d == {1'b0, target_q}) begin
                fin     = 1'b1;
                fin_st  = dats_pkg::StFound;
                phase_d = dats_pkg::PhDone;
                fin_off = pos_x[dats_pkg::OffsetWidth-1:0];
                fin_len = lacc_d[dats_pkg::TypeWidth-1:0];
              end else if (end_x < pos_x) begin
                fin = 1'b1; fin_st = dats_pkg::StBackSkip; phase_d = dats_pkg::PhDone;
              end else if (end_x + CW'(dats_pkg::MinElemBytes) >= tot_x) begin
                fin = 1'b1; fin_st = dats_pkg::StDataEnd; phase_d = dats_pkg::PhDone;
              end else if (end_x == pos_x) begin
                phase_d = dats_pkg::PhElemTag;
              end else begin
                phase_d = dats_pkg::PhSkip;
              end
            end
          endcase
        end

        if (at_end && phase_d == dats_pkg::PhIntVal) begin
          phase_d = dats_pkg::PhA1Tag;
        end

        if (phase_d == dats_pkg::PhElemTag) begin
          if (pos_x + CW'(dats_pkg::MinElemBytes) >= tot_x) begin
            fin = 1'b1; fin_st = dats_pkg::StDataEnd; phase_d = dats_pkg::PhDone;
          end
        end else if (phase_d != dats_pkg::PhDone && phase_d != dats_pkg::PhSkip && at_end) begin
          fin = 1'b1; fin_st = dats_pkg::StDataEnd; phase_d = dats_pkg::PhDone;
        end
      end
    end

    if (fin) begin
      given_d = 1'b1;
    end

    emit_o               = fin;
    res_o.found          = (fin_st == dats_pkg::StFound);
    res_o.status         = fin_st;
    res_o.payload_offset = fin_off;
    res_o.payload_length = fin_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= dats_pkg::TargetReset;
      pos_q    <= '0;
      phase_q  <= dats_pkg::PhOuterTag;
      lacc_q   <= '0;
      lleft_q  <= '0;
      tacc_q   <= '0;
      tleft_q  <= '0;
      eend_q   <= '0;
      tot_q    <= '0;
      given_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (step_i) begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        lacc_q  <= lacc_d;
        lleft_q <= lleft_d;
        tacc_q  <= tacc_d;
        tleft_q <= tleft_d;
        eend_q  <= eend_d;
        tot_q   <= tot_d;
        given_q <= given_d;
      end
    end
  end

endmodule

// ----- rtl/dats_out_stage.sv -----
// Result register that holds one finished scan result until taken.
`timescale 1ns / 1ps

module dats_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dats_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output dats_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  dats_pkg::result_t res_q;

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- rtl/der_authdata_type_scanner.sv -----
// Top level of the DER authorization-data type scanner.
// The final byte waits in the input register, then its result loads the result register.
// Throughput: one byte per cycle; the parser step is combinational between the input
// register and the result register, and a result waiting on out_ready_i holds the input.
// Reset: asynchronous, active low; clears the parser state and sets target_type to 128.
`timescale 1ns / 1ps

module der_authdata_type_scanner #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] buffer_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [2:0]  status_o,
  output logic [15:0] payload_offset_o,
  output logic [30:0] payload_length_o,
  input  logic        target_type_we_i,
  input  logic [30:0] target_type_i
);

  dats_pkg::item_t   item_in;
  dats_pkg::item_t   item_q;
  logic              item_valid;
  logic              step;
  logic              emit;
  dats_pkg::result_t res_d;
  dats_pkg::result_t res_q;

  assign item_in.data_byte     = data_byte_i;
  assign item_in.first_byte    = first_byte_i;
  assign item_in.buffer_length = buffer_length_i;

  assign step = item_valid && (!out_valid_o || out_ready_i);

  dats_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item_q)
  );

  dats_core #(
    .PositionWidth (POSITION_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (target_type_we_i),
    .cfg_data_i (target_type_i),
    .step_i     (step),
    .item_i     (item_q),
    .emit_o     (emit),
    .res_o      (res_d)
  );

  dats_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .res_i       (res_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign found_o          = res_q.found;
  assign status_o         = res_q.status;
  assign payload_offset_o = res_q.payload_offset;
  assign payload_length_o = res_q.payload_length;

endmodule

// ----- test/tb_der_authdata_type_scanner.sv -----
// Self-checking testbench for the DER authorization-data type scanner.
`timescale 1ns / 1ps

module tb_der_authdata_type_scanner;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic [15:0] buffer_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        found_o;
  logic [2:0]  status_o;
  logic [15:0] payload_offset_o;
  logic [30:0] payload_length_o;
  logic        target_type_we_i;
  logic [30:0] target_type_i;

  der_authdata_type_scanner DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .buffer_length_i (buffer_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .status_o        (status_o),
    .payload_offset_o(payload_offset_o),
    .payload_length_o(payload_length_o),
    .target_type_we_i(target_type_we_i),
    .target_type_i   (target_type_i)
  );

  dats_pkg::item_t   bytes_q[$];
  dats_pkg::result_t reports_q[$];
  logic [7:0]  buf_q[$];
  int          queued;
  int          bad_results;
  bit          byte_taken;
  bit          steady;

  dats_pkg::phase_e  scan_phase;
  logic [15:0] scan_pos;
  logic [15:0] scan_total;
  logic [31:0] scan_len_acc;
  logic [6:0]  scan_len_left;
  logic [31:0] scan_type_acc;
  logic [7:0]  scan_type_left;
  logic [32:0] scan_elem_end;
  bit          scan_done;
  dats_pkg::result_t scan_report;
  logic [30:0] match_type;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic dats_pkg::phase_e phase_after(dats_pkg::phase_e p);
    case (p)
      dats_pkg::PhOuterTag: return dats_pkg::PhOuterLen;
      dats_pkg::PhOuterLen: return dats_pkg::PhOuterMore;
      dats_pkg::PhElemTag:  return dats_pkg::PhSeqLen;
      dats_pkg::PhSeqLen:   return dats_pkg::PhSeqMore;
      dats_pkg::PhA0Tag:    return dats_pkg::PhA0Len;
      dats_pkg::PhA0Len:    return dats_pkg::PhA0More;
      dats_pkg::PhIntTag:   return dats_pkg::PhIntLen;
      dats_pkg::PhA1Tag:    return dats_pkg::PhA1Len;
      dats_pkg::PhA1Len:    return dats_pkg::PhA1More;
      dats_pkg::PhOctTag:   return dats_pkg::PhOctLen;
      dats_pkg::PhOctLen:   return dats_pkg::PhOctMore;
      default:              return p;
    endcase
  endfunction

  task automatic scan_clear();
    scan_pos       = '0;
    scan_phase     = dats_pkg::PhOuterTag;
    scan_len_acc   = '0;
    scan_len_left  = '0;
    scan_type_acc  = '0;
    scan_type_left = '0;
    scan_elem_end  = '0;
    scan_done      = 1'b0;
  endtask

  task automatic scan_finish(input dats_pkg::status_e st, input logic [15:0] off,
                             input logic [30:0] len);
    scan_done                  = 1'b1;
    scan_phase                 = dats_pkg::PhDone;
    scan_report.found          = (st == dats_pkg::StFound);
    scan_report.status         = st;
    scan_report.payload_offset = off;
    scan_report.payload_length = len;
  endtask

  task automatic scan_skip_end();
    if (scan_elem_end < scan_pos) begin
      scan_finish(dats_pkg::StBackSkip, '0, '0);
    end else if (scan_elem_end + 34'd6 >= scan_total) begin
      scan_finish(dats_pkg::StDataEnd, '0, '0);
    end else if (scan_elem_end == scan_pos) begin
      scan_phase = dats_pkg::PhElemTag;
    end else begin
      scan_phase = dats_pkg::PhSkip;
    end
  endtask

  task automatic scan_length_done();
    case (scan_phase)
      dats_pkg::PhOuterLen, dats_pkg::PhOuterMore: scan_phase = dats_pkg::PhElemTag;
      dats_pkg::PhSeqLen, dats_pkg::PhSeqMore: begin
        if (scan_len_acc[31]) begin
          scan_finish(dats_pkg::StBadElem, '0, '0);
        end else begin
          scan_elem_end = scan_pos + scan_len_acc;
          scan_phase    = dats_pkg::PhA0Tag;
        end
      end
      dats_pkg::PhA0Len, dats_pkg::PhA0More: scan_phase = dats_pkg::PhIntTag;
      dats_pkg::PhA1Len, dats_pkg::PhA1More: scan_phase = dats_pkg::PhOctTag;
      default: begin
        if (scan_len_acc[31]) begin
          scan_finish(dats_pkg::StBadElem, '0, '0);
        end else if (scan_type_acc == match_type) begin
          scan_finish(dats_pkg::StFound, scan_pos, scan_len_acc[30:0]);
        end else begin
          scan_skip_end();
        end
      end
    endcase
  endtask

  task automatic scan_tag(input logic [7:0] b, input logic [7:0] want,
                          input dats_pkg::status_e fail);
    if (b == want) begin
      scan_phase = phase_after(scan_phase);
    end else begin
      scan_finish(fail, '0, '0);
    end
  endtask

  task automatic scan_take(input logic [7:0] b);
    scan_pos = scan_pos + 16'd1;
    case (scan_phase)
      dats_pkg::PhOuterTag: scan_tag(b, dats_pkg::TagSeq, dats_pkg::StBadOuter);
      dats_pkg::PhElemTag:  scan_tag(b, dats_pkg::TagSeq, dats_pkg::StBadElem);
      dats_pkg::PhA0Tag:    scan_tag(b, dats_pkg::TagCtx0, dats_pkg::StBadElem);
      dats_pkg::PhIntTag:   scan_tag(b, dats_pkg::TagInt, dats_pkg::StBadElem);
      dats_pkg::PhA1Tag:    scan_tag(b, dats_pkg::TagCtx1, dats_pkg::StBadElem);
      dats_pkg::PhOctTag:   scan_tag(b, dats_pkg::TagOct, dats_pkg::StBadElem);
      dats_pkg::PhOuterLen, dats_pkg::PhSeqLen, dats_pkg::PhA0Len,
      dats_pkg::PhA1Len, dats_pkg::PhOctLen: begin
        if (!b[dats_pkg::LongFormBit]) begin
          scan_len_acc = {24'd0, b};
          scan_length_done();
        end else begin
          scan_len_acc  = '0;
          scan_len_left = b[6:0];
          if (scan_len_left == 0) scan_length_done();
          else scan_phase = phase_after(scan_phase);
        end
      end
      dats_pkg::PhOuterMore, dats_pkg::PhSeqMore, dats_pkg::PhA0More,
      dats_pkg::PhA1More, dats_pkg::PhOctMore: begin
        scan_len_acc  = {scan_len_acc[23:0], b};
        scan_len_left = scan_len_left - 7'd1;
        if (scan_len_left == 0) scan_length_done();
      end
      dats_pkg::PhIntLen: begin
        scan_type_left = b;
        scan_type_acc  = '0;
        scan_phase     = (b != 0) ? dats_pkg::PhIntVal : dats_pkg::PhA1Tag;
      end
      dats_pkg::PhIntVal: begin
        scan_type_acc  = {scan_type_acc[23:0], b};
        scan_type_left = scan_type_left - 8'd1;
        if (scan_type_left == 0) scan_phase = dats_pkg::PhA1Tag;
      end
      dats_pkg::PhSkip: begin
        if (scan_elem_end == scan_pos) scan_phase = dats_pkg::PhElemTag;
      end
      default: ;
    endcase
  endtask

  task automatic scan_settle();
    bit at_end;
    at_end = scan_pos >= scan_total;
    if (at_end && (scan_phase == dats_pkg::PhOuterMore || scan_phase == dats_pkg::PhSeqMore ||
                   scan_phase == dats_pkg::PhA0More || scan_phase == dats_pkg::PhA1More ||
                   scan_phase == dats_pkg::PhOctMore))
      scan_length_done();
    if (at_end && scan_phase == dats_pkg::PhIntVal) scan_phase = dats_pkg::PhA1Tag;
    if (scan_phase == dats_pkg::PhElemTag) begin
      if (scan_pos + 33'd6 >= scan_total) scan_finish(dats_pkg::StDataEnd, '0, '0);
    end else if (scan_phase != dats_pkg::PhDone && scan_phase != dats_pkg::PhSkip &&
                 at_end) begin
      scan_finish(dats_pkg::StDataEnd, '0, '0);
    end
  endtask

  task automatic scan_step(input logic [7:0] b, input logic first, input logic [15:0] blen,
                           output bit got);
    got = 1'b0;
    if (first) begin
      scan_clear();
      scan_total = blen;
    end
    if (first || !scan_done) begin
      if (scan_pos >= scan_total) begin
        scan_finish(dats_pkg::StDataEnd, '0, '0);
      end else begin
        scan_take(b);
        if (!scan_done) scan_settle();
      end
      got = scan_done;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first, input logic [15:0] blen);
    dats_pkg::item_t it;
    it.data_byte     = b;
    it.first_byte    = first;
    it.buffer_length = blen;
    bytes_q.push_back(it);
    queued++;
  endtask

  task automatic send_buf(input logic [15:0] blen);
    foreach (buf_q[i]) push_byte(buf_q[i], i == 0, blen);
  endtask

  task automatic put_len(input logic [31:0] v);
    int n;
    int pad;
    n = (v > 32'hFF_FFFF) ? 4 : (v > 32'hFFFF) ? 3 : (v > 32'hFF) ? 2 : (v != 0) ? 1 : 0;
    if (v < 128 && $urandom_range(9) < 6) begin
      buf_q.push_front(v[7:0]);
    end else begin
      pad = ($urandom_range(7) == 0) ? 1 : 0;
      if (n == 0 && $urandom_range(1) == 1) n = 1;
      for (int i = 0; i < n + pad; i++) buf_q.push_front(8'(v >> (8 * i)));
      buf_q.push_front(8'h80 | 8'(n + pad));
    end
  endtask

  task automatic add_element(input bit hit);
    int          mark;
    int          plen;
    int          nb;
    logic [31:0] tv;
    logic [31:0] olen;
    logic [31:0] slen;
    mark = buf_q.size();
    plen = $urandom_range(5);
    for (int i = 0; i < plen; i++) buf_q.push_front(8'($urandom));
    olen = plen;
    case ($urandom_range(19))
      0: olen = 32'h8000_0000 | $urandom;
      1: olen = $urandom_range(300, 70000);
      default: ;
    endcase
    put_len(olen);
    buf_q.push_front(dats_pkg::TagOct);
    put_len(buf_q.size() - mark);
    buf_q.push_front(dats_pkg::TagCtx1);
    if (hit) tv = {1'b0, match_type};
    else if ($urandom_range(3) == 0) tv = {1'b0, match_type} ^ (32'd1 << $urandom_range(31));
    else tv = $urandom;
    if (hit) begin
      nb = (tv[31:24] != 0) ? 4 : (tv[23:16] != 0) ? 3 : (tv[15:8] != 0) ? 2 :
           (tv[7:0] != 0) ? 1 : 0;
      nb = nb + $urandom_range(2);
    end else begin
      nb = $urandom_range(6);
    end
    for (int i = 0; i < nb; i++)
      buf_q.push_front(i < 4 ? 8'(tv >> (8 * i)) : 8'($urandom));
    buf_q.push_front(8'(nb));
    buf_q.push_front(dats_pkg::TagInt);
    put_len(buf_q.size() - mark);
    buf_q.push_front(dats_pkg::TagCtx0);
    slen = buf_q.size() - mark;
    case ($urandom_range(29))
      0: slen = 32'h8000_0000 | $urandom;
      1: slen = $urandom_range(slen);
      2: slen = slen + $urandom_range(1, 40);
      default: ;
    endcase
    put_len(slen);
    buf_q.push_front(dats_pkg::TagSeq);
  endtask

  task automatic add_buffer();
    int n_el;
    int hit_at;
    int blen;
    buf_q.delete();
    if ($urandom_range(24) == 0) begin
      for (int i = $urandom_range(1, 20); i > 0; i--) buf_q.push_back(8'($urandom));
      if ($urandom_range(1) == 1) buf_q[0] = dats_pkg::TagSeq;
    end else begin
      n_el   = $urandom_range(1, 4);
      hit_at = $urandom_range(n_el);
      for (int e = n_el - 1; e >= 0; e--) add_element(e == hit_at);
      put_len(buf_q.size());
      buf_q.push_front(dats_pkg::TagSeq);
      if ($urandom_range(6) == 0) buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom);
    end
    case ($urandom_range(9))
      0: blen = $urandom_range(1, buf_q.size());
      1: blen = $urandom_range(buf_q.size(), 16'hFFFF);
      default: blen = buf_q.size();
    endcase
    send_buf(16'(blen));
    if ($urandom_range(7) == 0)
      for (int i = $urandom_range(1, 3); i > 0; i--) push_byte(8'($urandom), 1'b0, 16'(blen));
  endtask

  task automatic wait_drained();
    int guard;
    while (bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    guard = 0;
    while (reports_q.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [30:0] tgt, input bit calm, input int n_items);
    wait_drained();
    target_type_i    <= tgt;
    target_type_we_i <= 1'b1;
    match_type        = tgt;
    @(negedge clk_i);
    target_type_we_i <= 1'b0;
    steady = calm;
    queued = 0;
    while (queued < n_items) add_buffer();
  endtask

  // driver: hold a request until taken, then advance or idle
  always @(negedge clk_i) begin
    dats_pkg::item_t nxt;
    out_ready_i <= steady || ($urandom_range(99) >= 27);
    if (!in_valid_i || byte_taken) begin
      if (bytes_q.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
        nxt = bytes_q.pop_front();
        in_valid_i      <= 1'b1;
        data_byte_i     <= nxt.data_byte;
        first_byte_i    <= nxt.first_byte;
        buffer_length_i <= nxt.buffer_length;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: predict on each taken request, then check each taken report
  always @(posedge clk_i) begin
    dats_pkg::result_t seen;
    dats_pkg::result_t want;
    bit      got;
    if (rst_ni) begin
      byte_taken = in_valid_i && in_ready_o;
      if (byte_taken) begin
        scan_step(data_byte_i, first_byte_i, buffer_length_i, got);
        if (got) reports_q.push_back(scan_report);
      end
      if (out_valid_o && out_ready_i) begin
        seen = {found_o, status_o, payload_offset_o, payload_length_o};
        if (reports_q.size() == 0) begin
          bad_results++;
          $display("%0t: unexpected report found=%0d status=%0d offset=%0d length=%0d",
                   $time, seen.found, seen.status, seen.payload_offset, seen.payload_length);
        end else begin
          want = reports_q.pop_front();
          if (seen !== want) begin
            bad_results++;
            $display("%0t: expected found=%0d status=%0d offset=%0d length=%0d", $time,
                     want.found, want.status, want.payload_offset, want.payload_length);
            $display("%0t: actual   found=%0d status=%0d offset=%0d length=%0d", $time,
                     seen.found, seen.status, seen.payload_offset, seen.payload_length);
          end
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = '0;
    first_byte_i     = 1'b0;
    buffer_length_i  = '0;
    out_ready_i      = 1'b0;
    target_type_we_i = 1'b0;
    target_type_i    = '0;
    steady           = 1'b0;
    byte_taken       = 1'b0;
    bad_results      = 0;
    queued           = 0;
    match_type       = dats_pkg::TargetReset;
    scan_clear();
    scan_total = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_byte(8'($urandom), 1'b0, 16'($urandom));
    push_byte(8'h31, 1'b1, 16'hFFFF);
    push_byte(dats_pkg::TagSeq, 1'b0, 16'hFFFF);
    push_byte(dats_pkg::TagSeq, 1'b1, 16'h0000);
    buf_q = '{8'h30, 8'h83, 8'h12};
    send_buf(16'd3);
    buf_q = '{8'h30, 8'h80, 8'h30, 8'h0B, 8'hA0, 8'h80, 8'h02, 8'h01, 8'h80,
              8'hA1, 8'h80, 8'h04, 8'h82, 8'h01, 8'h00};
    send_buf(16'd15);

    run_phase(31'd0, 1'b0, 320);
    run_phase(31'h7FFF_FFFF, 1'b0, 320);
    run_phase(31'($urandom_range(1, 300)), 1'b1, 320);
    run_phase(31'($urandom), 1'b0, 320);
    run_phase(dats_pkg::TargetReset, 1'b0, 320);
    run_phase(31'($urandom_range(255)), 1'b0, 320);
    wait_drained();

    if (reports_q.size() != 0) begin
      bad_results++;
      $display("%0t: %0d expected reports never arrived", $time, reports_q.size());
    end
    if (bad_results == 0) begin
      $display("der_authdata_type_scanner: match");
    end else begin
      $display("der_authdata_type_scanner: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("der_authdata_type_scanner: mismatch");
    $finish;
  end

endmodule

// ----- der_authdata_type_scanner.f -----
rtl/dats_pkg.sv
rtl/dats_in_stage.sv
rtl/dats_core.sv
rtl/dats_out_stage.sv
rtl/der_authdata_type_scanner.sv
test/tb_der_authdata_type_scanner.sv
